>>> rtl/core/lfucs_pkg.sv
// ----------------------------------------------------------------------------
// lfucs_pkg: shared types and constants of the LFU cache set
// Operation codes, controller states and the command bundle that the
// controller broadcasts to every way cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lfucs_pkg;

  // Field widths fixed by the interface
  localparam int KIND_BITS    = 2;
  localparam int CFG_BITS     = 4;
  localparam int OCC_OUT_BITS = 4;

  // ways_in_use after reset
  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  // Operation codes carried by in_kind
  typedef enum logic [KIND_BITS-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP
  } state_e;

  // Command broadcast to all cells in the update cycle
  typedef struct packed {
    logic upd;       // apply the operation at this edge
    op_e  op;        // operation
    logic hit;       // some valid entry matches the tag
    logic free_any;  // some usable way is free
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/lfu_cache_set_unit.sv
// ----------------------------------------------------------------------------
// lfu_cache_set_unit: fully associative cache set with LFU victim report
// Usage:
//   Input channel (in_valid/in_ready) carries kind (lookup, insert, remove,
//   no-op), tag and start_count. Each transfer yields exactly one result
//   on the output channel (out_valid/out_ready): hit, use_count, occupancy,
//   the least frequently used victim (ties to the oldest insert) and rejected.
//   cfg_we/cfg_wdata write ways_in_use; write it only while the set is idle.
//   The set works on one item at a time: a new item is taken only after
//   the previous one has loaded the output register. All ways are updated
//   together, after which the victim and occupancy ripple through a chain
//   of WAYS registered way cells, one cell per cycle, and then the result
//   is loaded into the output register.
//   The result sits in an output register; a new item is taken while it
//   waits. If the receiver stalls with a result still held, the next item
//   finishes its sweep and waits until the output register frees up.
//   Reset (rst_n low, synchronous) empties the set, drops any item in
//   flight and sets ways_in_use to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_set_unit #(
  parameter int WAYS       = 8,
  parameter int TAG_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire  [lfucs_pkg::CFG_BITS-1:0]        cfg_wdata,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [lfucs_pkg::KIND_BITS-1:0]       in_kind,
  input  wire  [TAG_BITS-1:0]                   in_tag,
  input  wire  [COUNT_BITS-1:0]                 in_start_count,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic                                  out_hit,
  output logic [COUNT_BITS-1:0]                 out_use_count,
  output logic [lfucs_pkg::OCC_OUT_BITS-1:0]    out_occupancy,
  output logic                                  out_victim_valid,
  output logic [TAG_BITS-1:0]                   out_victim_tag,
  output logic [COUNT_BITS-1:0]                 out_victim_count,
  output logic                                  out_rejected
);

  localparam int AGE_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int OCC_BITS = $clog2(WAYS + 1);
  localparam int CNT_BITS = $clog2(WAYS + 1);
  localparam logic [CNT_BITS-1:0] SWEEP_LEN = CNT_BITS'(WAYS);

  lfucs_pkg::state_e state_r, state_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [lfucs_pkg::CFG_BITS-1:0] ways_in_use_r;

  // Held item
  lfucs_pkg::op_e        op_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [COUNT_BITS-1:0] sc_r;

  // Per-item results formed in the update cycle
  logic                  hit_r, hit_nxt;
  logic [COUNT_BITS-1:0] uc_r, uc_nxt;
  logic                  rej_r, rej_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;
  logic [COUNT_BITS-1:0] out_uc_r;
  logic [lfucs_pkg::OCC_OUT_BITS-1:0] out_occ_r;
  logic                  out_vv_r;
  logic [TAG_BITS-1:0]   out_vtag_r;
  logic [COUNT_BITS-1:0] out_vcnt_r;
  logic                  out_rej_r;

  logic load_item, exec, load_out;

  // Way signals
  logic [WAYS-1:0]       valid_vec, match_vec, in_use_vec, free_vec, sel_vec;
  logic [COUNT_BITS-1:0] way_count [WAYS];
  logic [AGE_BITS-1:0]   way_age [WAYS];
  logic                  match_any, free_any;
  logic [COUNT_BITS-1:0] m_count;
  logic [AGE_BITS-1:0]   m_age;
  lfucs_pkg::cell_cmd_t  cmd;

  // Victim chain links; link 0 is the empty seed
  logic [WAYS:0]         lnk_found;
  logic [TAG_BITS-1:0]   lnk_tag   [WAYS+1];
  logic [COUNT_BITS-1:0] lnk_count [WAYS+1];
  logic [AGE_BITS-1:0]   lnk_age   [WAYS+1];
  logic [OCC_BITS-1:0]   lnk_occ   [WAYS+1];

  assign lnk_found[0] = 1'b0;
  assign lnk_tag[0]   = '0;
  assign lnk_count[0] = '0;
  assign lnk_age[0]   = '0;
  assign lnk_occ[0]   = '0;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_in_use_r <= lfucs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      ways_in_use_r <= cfg_wdata;
    end
  end

  // Ways below ways_in_use may take new entries
  for (genvar i = 0; i < WAYS; i++) begin : g_use
    assign in_use_vec[i] = int'(ways_in_use_r) > i;
  end

  // Free way search: isolate the lowest free usable way
  assign free_vec  = ~valid_vec & in_use_vec;
  assign sel_vec   = free_vec & (~free_vec + WAYS'(1));
  assign free_any  = |free_vec;
  assign match_any = |match_vec;

  // Read the matched entry through a one-hot mux
  always_comb begin
    m_count = '0;
    m_age   = '0;
    for (int i = 0; i < WAYS; i++) begin
      m_count = m_count | (way_count[i] & {COUNT_BITS{match_vec[i]}});
      m_age   = m_age   | (way_age[i]   & {AGE_BITS{match_vec[i]}});
    end
  end

  always_comb begin
    cmd.upd      = exec;
    cmd.op       = op_r;
    cmd.hit      = match_any;
    cmd.free_any = free_any;
  end

  // Way cells
  for (genvar i = 0; i < WAYS; i++) begin : g_way
    lfucs_cell #(
      .TAG_BITS  (TAG_BITS),
      .COUNT_BITS(COUNT_BITS),
      .AGE_BITS  (AGE_BITS),
      .OCC_BITS  (OCC_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd),
      .cmd_tag_i  (tag_r),
      .cmd_count_i(sc_r),
      .cmd_age_i  (m_age),
      .sel_free_i (sel_vec[i]),
      .valid_o    (valid_vec[i]),
      .match_o    (match_vec[i]),
      .count_o    (way_count[i]),
      .age_o      (way_age[i]),
      .lnk_found_i(lnk_found[i]),
      .lnk_tag_i  (lnk_tag[i]),
      .lnk_count_i(lnk_count[i]),
      .lnk_age_i  (lnk_age[i]),
      .lnk_occ_i  (lnk_occ[i]),
      .lnk_found_o(lnk_found[i+1]),
      .lnk_tag_o  (lnk_tag[i+1]),
      .lnk_count_o(lnk_count[i+1]),
      .lnk_age_o  (lnk_age[i+1]),
      .lnk_occ_o  (lnk_occ[i+1])
    );
  end

  // Per-item result fields
  always_comb begin
    hit_nxt = 1'b0;
    uc_nxt  = '0;
    rej_nxt = 1'b0;
    unique case (op_r)
      lfucs_pkg::OP_LOOKUP: begin
        hit_nxt = match_any;
        if (match_any) begin
          uc_nxt = (m_count == {COUNT_BITS{1'b1}}) ? m_count
                                                    : m_count + COUNT_BITS'(1);
        end
      end
      lfucs_pkg::OP_INSERT: begin
        hit_nxt = match_any;
        uc_nxt  = match_any ? sc_r : '0;
        rej_nxt = !match_any && !free_any;
      end
      lfucs_pkg::OP_REMOVE: begin
        hit_nxt = match_any;
        uc_nxt  = match_any ? m_count : '0;
      end
      lfucs_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // Controller: take item, update all ways, sweep the victim chain
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    load_item = 1'b0;
    exec      = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      lfucs_pkg::ST_IDLE: begin
        if (in_valid) begin
          load_item = 1'b1;
          state_nxt = lfucs_pkg::ST_EXEC;
        end
      end
      lfucs_pkg::ST_EXEC: begin
        exec      = 1'b1;
        cnt_nxt   = '0;
        state_nxt = lfucs_pkg::ST_SWEEP;
      end
      lfucs_pkg::ST_SWEEP: begin
        if (cnt_r == SWEEP_LEN) begin
          if (!out_valid_r || out_ready) begin
            load_out  = 1'b1;
            state_nxt = lfucs_pkg::ST_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_BITS'(1);
        end
      end
      default: begin
        state_nxt = lfucs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == lfucs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfucs_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold the item and its early results
  always_ff @(posedge clk) begin
    if (load_item) begin
      op_r  <= lfucs_pkg::op_e'(in_kind);
      tag_r <= in_tag;
      sc_r  <= in_start_count;
    end
    if (exec) begin
      hit_r <= hit_nxt;
      uc_r  <= uc_nxt;
      rej_r <= rej_nxt;
    end
  end

  // Output register: drop on transfer, load at sweep end
  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit_r  <= hit_r;
      out_uc_r   <= uc_r;
      out_occ_r  <= lfucs_pkg::OCC_OUT_BITS'(lnk_occ[WAYS]);
      out_vv_r   <= lnk_found[WAYS];
      out_vtag_r <= lnk_tag[WAYS];
      out_vcnt_r <= lnk_count[WAYS];
      out_rej_r  <= rej_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_use_count    = out_uc_r;
  assign out_occupancy    = out_occ_r;
  assign out_victim_valid = out_vv_r;
  assign out_victim_tag   = out_vtag_r;
  assign out_victim_count = out_vcnt_r;
  assign out_rejected     = out_rej_r;

endmodule

`default_nettype wire

>>> rtl/core/lfucs_cell.sv
// ----------------------------------------------------------------------------
// lfucs_cell: one way of the LFU cache set
// Holds the tag, use count, age rank and valid bit of one entry, applies the
// broadcast command, and forms one registered stage of the victim chain.
// ----------------------------------------------------------------------------
`default_nettype none

module lfucs_cell #(
  parameter int TAG_BITS   = 24,
  parameter int COUNT_BITS = 16,
  parameter int AGE_BITS   = 3,
  parameter int OCC_BITS   = 4
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire lfucs_pkg::cell_cmd_t  cmd_i,
  input  wire  [TAG_BITS-1:0]        cmd_tag_i,
  input  wire  [COUNT_BITS-1:0]      cmd_count_i,
  input  wire  [AGE_BITS-1:0]        cmd_age_i,
  input  wire                        sel_free_i,
  output logic                       valid_o,
  output logic                       match_o,
  output logic [COUNT_BITS-1:0]      count_o,
  output logic [AGE_BITS-1:0]        age_o,
  input  wire                        lnk_found_i,
  input  wire  [TAG_BITS-1:0]        lnk_tag_i,
  input  wire  [COUNT_BITS-1:0]      lnk_count_i,
  input  wire  [AGE_BITS-1:0]        lnk_age_i,
  input  wire  [OCC_BITS-1:0]        lnk_occ_i,
  output logic                       lnk_found_o,
  output logic [TAG_BITS-1:0]        lnk_tag_o,
  output logic [COUNT_BITS-1:0]      lnk_count_o,
  output logic [AGE_BITS-1:0]        lnk_age_o,
  output logic [OCC_BITS-1:0]        lnk_occ_o
);

  logic                  valid_r, valid_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [AGE_BITS-1:0]   age_r, age_nxt;

  logic                  lnk_found_r, lnk_found_nxt;
  logic [TAG_BITS-1:0]   lnk_tag_r, lnk_tag_nxt;
  logic [COUNT_BITS-1:0] lnk_count_r, lnk_count_nxt;
  logic [AGE_BITS-1:0]   lnk_age_r, lnk_age_nxt;
  logic [OCC_BITS-1:0]   lnk_occ_r, lnk_occ_nxt;

  logic better;

  assign valid_o = valid_r;
  assign match_o = valid_r && (tag_r == cmd_tag_i);
  assign count_o = count_r;
  assign age_o   = age_r;

  // Apply the broadcast operation to this entry
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    count_nxt = count_r;
    age_nxt   = age_r;
    if (cmd_i.upd) begin
      unique case (cmd_i.op)
        lfucs_pkg::OP_LOOKUP: begin
          if (match_o && (count_r != {COUNT_BITS{1'b1}})) begin
            count_nxt = count_r + COUNT_BITS'(1);
          end
        end
        lfucs_pkg::OP_INSERT: begin
          if (cmd_i.hit) begin
            // replace: matched entry becomes newest, younger ones age
            if (match_o) begin
              count_nxt = cmd_count_i;
              age_nxt   = '0;
            end else if (valid_r && (age_r < cmd_age_i)) begin
              age_nxt = age_r + AGE_BITS'(1);
            end
          end else if (cmd_i.free_any) begin
            // new entry in the selected free way, all other valid entries age
            if (sel_free_i) begin
              valid_nxt = 1'b1;
              tag_nxt   = cmd_tag_i;
              count_nxt = cmd_count_i;
              age_nxt   = '0;
            end else if (valid_r) begin
              age_nxt = age_r + AGE_BITS'(1);
            end
          end
        end
        lfucs_pkg::OP_REMOVE: begin
          if (cmd_i.hit) begin
            if (match_o) begin
              valid_nxt = 1'b0;
            end else if (valid_r && (age_r > cmd_age_i)) begin
              age_nxt = age_r - AGE_BITS'(1);
            end
          end
        end
        lfucs_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the entry; only the valid bit needs reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r   <= tag_nxt;
    count_r <= count_nxt;
    age_r   <= age_nxt;
  end

  // Victim stage: lowest count wins, ties go to the older entry
  assign better = valid_r && (!lnk_found_i || (count_r < lnk_count_i) ||
                              ((count_r == lnk_count_i) && (age_r > lnk_age_i)));

  always_comb begin
    lnk_found_nxt = lnk_found_i || valid_r;
    lnk_tag_nxt   = better ? tag_r   : lnk_tag_i;
    lnk_count_nxt = better ? count_r : lnk_count_i;
    lnk_age_nxt   = better ? age_r   : lnk_age_i;
    lnk_occ_nxt   = lnk_occ_i + OCC_BITS'(valid_r);
  end

  // Advance the chain every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lnk_found_r <= 1'b0;
    end else begin
      lnk_found_r <= lnk_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lnk_tag_r   <= lnk_tag_nxt;
    lnk_count_r <= lnk_count_nxt;
    lnk_age_r   <= lnk_age_nxt;
    lnk_occ_r   <= lnk_occ_nxt;
  end

  assign lnk_found_o = lnk_found_r;
  assign lnk_tag_o   = lnk_tag_r;
  assign lnk_count_o = lnk_count_r;
  assign lnk_age_o   = lnk_age_r;
  assign lnk_occ_o   = lnk_occ_r;

endmodule

`default_nettype wire

>>> rtl/core/lfucs_chk.sv
// ----------------------------------------------------------------------------
// lfucs_chk: port-level checker for the LFU cache set
// Watches the top level's ports and flags results that break the set's
// rules; attached to the top level by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module lfucs_chk #(
  parameter int TAG_BITS   = 24,
  parameter int COUNT_BITS = 16
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                cfg_we,
  input wire [lfucs_pkg::CFG_BITS-1:0]      cfg_wdata,
  input wire                                in_valid,
  input wire                                in_ready,
  input wire [lfucs_pkg::KIND_BITS-1:0]     in_kind,
  input wire [TAG_BITS-1:0]                 in_tag,
  input wire [COUNT_BITS-1:0]               in_start_count,
  input wire                                out_valid,
  input wire                                out_ready,
  input wire                                out_hit,
  input wire [COUNT_BITS-1:0]               out_use_count,
  input wire [lfucs_pkg::OCC_OUT_BITS-1:0]  out_occupancy,
  input wire                                out_victim_valid,
  input wire [TAG_BITS-1:0]                 out_victim_tag,
  input wire [COUNT_BITS-1:0]               out_victim_count,
  input wire                                out_rejected
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_victim_tag) &&
      $stable(out_use_count) && $stable(out_victim_count))
    else $error("stalled result changed");

  // One item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Empty set reports a zero victim and zero occupancy
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_victim_valid |-> out_occupancy == '0 &&
      out_victim_tag == '0 && out_victim_count == '0)
    else $error("empty set reports a victim");

  // A rejected insert never hits
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> !out_hit && out_use_count == '0)
    else $error("rejected insert reports a hit");

  // A miss reports a zero count
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_use_count == '0)
    else $error("miss reports a use count");

endmodule

bind lfu_cache_set_unit lfucs_chk #(
  .TAG_BITS  (TAG_BITS),
  .COUNT_BITS(COUNT_BITS)
) u_lfucs_chk (.*);

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lfu_cache_set_unit
// Runs directed accesses and then randomized traffic through the set under
// a range of ways_in_use settings. A behavioral copy of the set predicts
// every result (hit, counts, occupancy, LFU victim, reject), and each
// output transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int WAYS         = 8;
  localparam int TAG_W        = 24;
  localparam int CNT_W        = 16;
  localparam int OCC_W        = lfucs_pkg::OCC_OUT_BITS;
  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic                    hit;
    logic [CNT_W-1:0]        use_count;
    logic [OCC_W-1:0]        occupancy;
    logic                    victim_valid;
    logic [TAG_W-1:0]        victim_tag;
    logic [CNT_W-1:0]        victim_count;
    logic                    rejected;
  } set_result_t;

  // DUT signals; the driven inputs are known from time zero
  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [lfucs_pkg::CFG_BITS-1:0]  cfg_wdata = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [lfucs_pkg::KIND_BITS-1:0] in_kind   = lfucs_pkg::OP_LOOKUP;
  logic [TAG_W-1:0]     in_tag         = '0;
  logic [CNT_W-1:0]     in_start_count = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 out_hit;
  logic [CNT_W-1:0]     out_use_count;
  logic [OCC_W-1:0]     out_occupancy;
  logic                 out_victim_valid;
  logic [TAG_W-1:0]     out_victim_tag;
  logic [CNT_W-1:0]     out_victim_count;
  logic                 out_rejected;

  // Shadow copy of the set
  logic [TAG_W-1:0] way_tag   [WAYS];
  logic [CNT_W-1:0] way_count [WAYS];
  bit               way_valid [WAYS];
  int               way_age   [WAYS];
  int               ways_limit = lfucs_pkg::CFG_RESET;

  set_result_t pending_results[$];

  int  error_count  = 0;
  int  cycle_count  = 0;
  int  n_accesses   = 0;
  int  n_hits       = 0;
  int  n_rejects    = 0;
  int  n_saturated  = 0;
  int  n_settings   = 0;
  bit  steady       = 1'b0;
  int  rx_left      = 0;
  bit  rx_stalled   = 1'b0;

  lfu_cache_set_unit #(
    .WAYS       (WAYS),
    .TAG_BITS   (TAG_W),
    .COUNT_BITS (CNT_W)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_tag           (in_tag),
    .in_start_count   (in_start_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_use_count    (out_use_count),
    .out_occupancy    (out_occupancy),
    .out_victim_valid (out_victim_valid),
    .out_victim_tag   (out_victim_tag),
    .out_victim_count (out_victim_count),
    .out_rejected     (out_rejected)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Count cycles for the watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
             cycle_count, pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, a few long ones; none in steady stretches
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Apply one access to the shadow set and return the result it gives
  function automatic set_result_t predict_access(lfucs_pkg::op_e k, logic [TAG_W-1:0] t,
                                                 logic [CNT_W-1:0] sc);
    set_result_t r;
    int hit_way, free_way, best, lim, old_age, occ;
    r = '0;
    hit_way = -1;
    free_way = -1;
    best = -1;
    occ = 0;
    lim = (ways_limit > WAYS) ? WAYS : ways_limit;
    for (int i = 0; i < WAYS; i++)
      if (hit_way < 0 && way_valid[i] && way_tag[i] == t) hit_way = i;

    case (k)
      lfucs_pkg::OP_LOOKUP: begin
        if (hit_way >= 0) begin
          if (way_count[hit_way] != COUNT_MAX) way_count[hit_way]++;
          r.hit = 1'b1;
          r.use_count = way_count[hit_way];
        end
      end
      lfucs_pkg::OP_INSERT: begin
        if (hit_way >= 0) begin
          // Replace: new count, entry becomes the newest insert
          way_count[hit_way] = sc;
          old_age = way_age[hit_way];
          for (int i = 0; i < WAYS; i++)
            if (way_valid[i] && i != hit_way && way_age[i] < old_age) way_age[i]++;
          way_age[hit_way] = 0;
          r.hit = 1'b1;
          r.use_count = sc;
        end else begin
          for (int i = 0; i < lim; i++)
            if (free_way < 0 && !way_valid[i]) free_way = i;
          if (free_way < 0) begin
            r.rejected = 1'b1;
          end else begin
            for (int i = 0; i < WAYS; i++)
              if (way_valid[i]) way_age[i]++;
            way_age[free_way]   = 0;
            way_valid[free_way] = 1'b1;
            way_tag[free_way]   = t;
            way_count[free_way] = sc;
          end
        end
      end
      lfucs_pkg::OP_REMOVE: begin
        if (hit_way >= 0) begin
          r.hit = 1'b1;
          r.use_count = way_count[hit_way];
          way_valid[hit_way] = 1'b0;
          for (int i = 0; i < WAYS; i++)
            if (way_valid[i] && way_age[i] > way_age[hit_way]) way_age[i]--;
        end
      end
      default: ;
    endcase

    // Lowest count wins, ties go to the oldest insert
    for (int i = 0; i < WAYS; i++) begin
      if (way_valid[i]) begin
        occ++;
        if (best < 0 || way_count[i] < way_count[best] ||
            (way_count[i] == way_count[best] && way_age[i] > way_age[best]))
          best = i;
      end
    end
    r.occupancy = OCC_W'(occ);
    if (best >= 0) begin
      r.victim_valid = 1'b1;
      r.victim_tag   = way_tag[best];
      r.victim_count = way_count[best];
    end
    return r;
  endfunction

  // Drive one access and record its predicted result on transfer
  task automatic send_op(lfucs_pkg::op_e k, logic [TAG_W-1:0] t, logic [CNT_W-1:0] sc);
    int gap;
    set_result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_tag         <= t;
    in_start_count <= sc;
    do @(posedge clk); while (!in_ready);
    r = predict_access(k, t, sc);
    pending_results.push_back(r);
    n_accesses++;
    if (r.hit) n_hits++;
    if (r.rejected) n_rejects++;
    if (k == lfucs_pkg::OP_LOOKUP && r.hit && r.use_count == COUNT_MAX) n_saturated++;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write ways_in_use once the set is quiet
  task automatic set_ways(int v);
    wait_idle();
    repeat (WAYS + 2) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= lfucs_pkg::CFG_BITS'(v);
    ways_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Receiver: alternate ready runs and stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      if (steady || $urandom_range(0, 99) < 55) begin
        rx_stalled = 1'b0;
        rx_left    = $urandom_range(1, 12);
      end else begin
        rx_stalled = 1'b1;
        rx_left    = pick_gap();
        if (rx_left == 0) rx_left = 1;
      end
    end
    rx_left--;
    out_ready <= !rx_stalled;
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    set_result_t want;
    set_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_hit, out_use_count, out_occupancy, out_victim_valid,
             out_victim_tag, out_victim_count, out_rejected};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transfer, actual %h", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("hit",          32'(want.hit),          32'(got.hit));
        check_field("use_count",    32'(want.use_count),    32'(got.use_count));
        check_field("occupancy",    32'(want.occupancy),    32'(got.occupancy));
        check_field("victim_valid", 32'(want.victim_valid), 32'(got.victim_valid));
        check_field("victim_tag",   32'(want.victim_tag),   32'(got.victim_tag));
        check_field("victim_count", 32'(want.victim_count), 32'(got.victim_count));
        check_field("rejected",     32'(want.rejected),     32'(got.rejected));
      end
    end
  end

  // Empty set: misses, a remove that finds nothing, and a no-op kind
  task automatic test_empty_set();
    send_op(lfucs_pkg::OP_LOOKUP, 24'h000000, 16'h0000);
    send_op(lfucs_pkg::OP_REMOVE, 24'hFFFFFF, 16'hFFFF);
    send_op(lfucs_pkg::OP_NOP,    24'hFFFFFF, 16'hFFFF);
  endtask

  // Fill all ways with extreme tags and counts, then overflow once
  task automatic test_fill_and_reject();
    send_op(lfucs_pkg::OP_INSERT, 24'h000000, 16'h0000);
    send_op(lfucs_pkg::OP_INSERT, 24'hFFFFFF, 16'hFFFF);
    send_op(lfucs_pkg::OP_INSERT, 24'h800001, 16'h0001);
    send_op(lfucs_pkg::OP_INSERT, 24'h7FFFFE, 16'h0000);
    send_op(lfucs_pkg::OP_INSERT, 24'h123456, 16'h0005);
    send_op(lfucs_pkg::OP_INSERT, 24'hABCDEF, 16'hFFFE);
    send_op(lfucs_pkg::OP_INSERT, 24'h55AA55, 16'h0002);
    send_op(lfucs_pkg::OP_INSERT, 24'hAA55AA, 16'h8000);
    send_op(lfucs_pkg::OP_INSERT, 24'h0F0F0F, 16'h0003);
  endtask

  // Hit counting up to and holding at the counter maximum
  task automatic test_counter_limit();
    send_op(lfucs_pkg::OP_LOOKUP, 24'hFFFFFF, 16'h0000);
    send_op(lfucs_pkg::OP_LOOKUP, 24'hABCDEF, 16'h0000);
    send_op(lfucs_pkg::OP_LOOKUP, 24'hABCDEF, 16'hFFFF);
    send_op(lfucs_pkg::OP_LOOKUP, 24'h000000, 16'h0000);
  endtask

  // Replace an existing tag, remove another tag, then remove that tag again
  task automatic test_replace_remove();
    send_op(lfucs_pkg::OP_INSERT, 24'h000000, 16'h0003);
    send_op(lfucs_pkg::OP_REMOVE, 24'h123456, 16'h0000);
    send_op(lfucs_pkg::OP_REMOVE, 24'h123456, 16'h0000);
  endtask

  // Zero, oversized and lowered ways_in_use
  task automatic test_way_limit();
    set_ways(0);
    send_op(lfucs_pkg::OP_INSERT, 24'h0F0F0F, 16'h0004);
    set_ways(15);
    send_op(lfucs_pkg::OP_INSERT, 24'h0F0F0F, 16'h0004);
    set_ways(2);
    send_op(lfucs_pkg::OP_REMOVE, 24'h55AA55, 16'h0000);
    send_op(lfucs_pkg::OP_INSERT, 24'h00FF00, 16'h0001);
    send_op(lfucs_pkg::OP_LOOKUP, 24'hAA55AA, 16'h0000);
  endtask

  // Random accesses over a pool of resident and fresh tags
  task automatic run_random_phase(int n_ops);
    logic [TAG_W-1:0] pool[$];
    logic [TAG_W-1:0] t;
    logic [CNT_W-1:0] sc;
    lfucs_pkg::op_e k;
    int r;
    for (int i = 0; i < WAYS; i++)
      if (way_valid[i]) pool.push_back(way_tag[i]);
    repeat ($urandom_range(2, 9)) pool.push_back(TAG_W'($urandom));
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 35)      k = lfucs_pkg::OP_LOOKUP;
      else if (r < 75) k = lfucs_pkg::OP_INSERT;
      else if (r < 93) k = lfucs_pkg::OP_REMOVE;
      else             k = lfucs_pkg::OP_NOP;
      t = pool[$urandom_range(0, pool.size() - 1)];
      r = $urandom_range(0, 99);
      if (r < 4)      t = TAG_W'($urandom);
      else if (r < 8) t = t ^ (TAG_W'(1) << $urandom_range(0, TAG_W - 1));
      r = $urandom_range(0, 99);
      if (r < 40)      sc = CNT_W'($urandom_range(0, 3));
      else if (r < 55) sc = CNT_W'($urandom_range(COUNT_MAX - 2, COUNT_MAX));
      else             sc = CNT_W'($urandom);
      send_op(k, t, sc);
    end
  endtask

  task automatic test_random_traffic();
    int plan[13] = '{1, 15, 0, 3, 8, 2, 6, 4, 12, 5, 7, 8, 9};
    for (int p = 0; p < 13; p++) begin
      set_ways(plan[p]);
      steady = (p == 4);
      run_random_phase(150);
    end
    steady = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < WAYS; i++) begin
      way_tag[i]   = '0;
      way_count[i] = '0;
      way_valid[i] = 1'b0;
      way_age[i]   = 0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_set();
    test_fill_and_reject();
    test_counter_limit();
    test_replace_remove();
    test_way_limit();
    test_random_traffic();

    // Drain, then allow the pipeline to settle
    wait_idle();
    repeat (WAYS + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, pending_results.size());
      error_count += pending_results.size();
    end

    $display("Ran %0d accesses over %0d ways_in_use settings: %0d hits, %0d rejected inserts,",
             n_accesses, n_settings, n_hits, n_rejects);
    $display("%0d lookups at the counter ceiling, %0d cycles", n_saturated, cycle_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
